### rtl/core/vertex_diffuse_lighting_unit_assert.svh
// Assertion macros for the checker of the vertex lighting block.
// Depends on nothing; the including module must have aclk and aresetn.
`ifndef VERTEX_DIFFUSE_LIGHTING_UNIT_ASSERT_SVH
`define VERTEX_DIFFUSE_LIGHTING_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VDL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("vertex lighting check failed");

// Consequent must hold in the cycle after the antecedent.
`define VDL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("vertex lighting check failed");

`endif

### rtl/core/vdl_pkg.sv
// Shared constants and types of the vertex diffuse lighting block.
// No dependencies; used by the lighting unit and the root and divide unit.
`timescale 1ns / 1ps

package vdl_pkg;

    // Light slots.
    localparam int NUM_LIGHTS  = 4;
    localparam int LIGHT_IDX_W = $clog2(NUM_LIGHTS);

    // Field widths.
    localparam int COORD_W = 24;
    localparam int COEF_W  = 16;
    localparam int MASK_W  = 4;
    localparam int BYTE_W  = 8;

    // Stream widths.
    localparam int S_DATA_W = 152;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 24;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_AMBIENT_RED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AMBIENT_GREEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AMBIENT_BLUE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIFFUSE_RED   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIFFUSE_GREEN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIFFUSE_BLUE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_ENABLE  = 3'd6;

    localparam logic [COEF_W-1:0] AMBIENT_RESET = 16'd410;
    localparam logic [COEF_W-1:0] DIFFUSE_RESET = 16'd4096;

    // Command codes carried in tuser.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_SHADE = 1'b1;

    // Root and divide unit.
    localparam int RAD_W      = 62;  // radicand bits
    localparam int ROOT_W     = 31;  // root and quotient bits
    localparam int REM_W      = 34;  // partial remainder bits
    localparam int NUM_W      = 43;  // dividend bits
    localparam int STEP_W     = 6;
    localparam int SQRT_STEPS = RAD_W / 2;
    localparam int DIV_STEPS  = NUM_W;

    typedef struct packed {
        logic start;
        logic op_sqrt;
    } rd_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rd_stat_t;

endpackage

### rtl/core/vdl_root_div.sv
// Shared shift-and-subtract unit: integer square root or unsigned division,
// one result bit per cycle. Depends on vdl_pkg.
`timescale 1ns / 1ps

module vdl_root_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  vdl_pkg::rd_ctrl_t            ctrl,
    input  logic [vdl_pkg::RAD_W-1:0]    operand,   // radicand, or dividend at the top
    input  logic [vdl_pkg::ROOT_W-1:0]   divisor,
    output vdl_pkg::rd_stat_t            stat,
    output logic [vdl_pkg::ROOT_W-1:0]   result
);

    logic                        busy_reg;
    logic                        done_reg;
    logic                        sqrt_reg;
    logic [vdl_pkg::STEP_W-1:0]  count_reg;
    logic [vdl_pkg::RAD_W-1:0]   x_reg;
    logic [vdl_pkg::REM_W-1:0]   rem_reg;
    logic [vdl_pkg::ROOT_W-1:0]  root_reg;
    logic [vdl_pkg::ROOT_W-1:0]  den_reg;

    logic [vdl_pkg::REM_W-1:0]   rem_sh;
    logic [vdl_pkg::REM_W-1:0]   trial;
    logic [vdl_pkg::REM_W-1:0]   diff;
    logic                        take;

    // One step: bring in the next operand bits and try the subtraction.
    always_comb begin
        if (sqrt_reg) begin
            rem_sh = {rem_reg[vdl_pkg::REM_W-3:0], x_reg[vdl_pkg::RAD_W-1 -: 2]};
            trial  = {1'b0, root_reg, 2'b01};
        end else begin
            rem_sh = {rem_reg[vdl_pkg::REM_W-2:0], x_reg[vdl_pkg::RAD_W-1]};
            trial  = {{(vdl_pkg::REM_W-vdl_pkg::ROOT_W){1'b0}}, den_reg};
        end
        take = (rem_sh >= trial);
        diff = rem_sh - trial;
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg  <= 1'b1;
                count_reg <= ctrl.op_sqrt ? vdl_pkg::STEP_W'(vdl_pkg::SQRT_STEPS - 1)
                                          : vdl_pkg::STEP_W'(vdl_pkg::DIV_STEPS - 1);
            end else if (busy_reg) begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            sqrt_reg <= ctrl.op_sqrt;
            x_reg    <= operand;
            rem_reg  <= '0;
            root_reg <= '0;
            den_reg  <= divisor;
        end else if (busy_reg) begin
            rem_reg  <= take ? diff : rem_sh;
            root_reg <= {root_reg[vdl_pkg::ROOT_W-2:0], take};
            x_reg    <= sqrt_reg ? {x_reg[vdl_pkg::RAD_W-3:0], 2'b00}
                                 : {x_reg[vdl_pkg::RAD_W-2:0], 1'b0};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = root_reg;

endmodule

### rtl/core/vertex_diffuse_lighting_unit.sv
// Per-vertex Lambert diffuse lighting. A load transfer (tuser[0] = 0) writes one
// light slot. A shade transfer (tuser[0] = 1) starts from ambient times diffuse
// and adds one term per enabled light through one shared 28x25 multiplier and one
// shift-and-subtract unit for the root and the divisions. A positional light adds
// a square root and three divisions unless it sits on the vertex. s_tready is low
// while a shade item is in work. The result sits in an output register, so a new
// item is taken while it waits. Slots read zero until they are loaded.
`timescale 1ns / 1ps

module vertex_diffuse_lighting_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // slot[1:0], vec_x, vec_y, vec_z, aux_x, aux_y, aux_z (24 bits each), zero pad
    input  logic [vdl_pkg::S_DATA_W-1:0]      s_tdata,
    // cmd[0], positional[1]
    input  logic [vdl_pkg::S_USER_W-1:0]      s_tuser,
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // red[7:0], green[15:8], blue[23:16]
    output logic [vdl_pkg::M_DATA_W-1:0]      m_tdata,
    // Configuration writes.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vdl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vdl_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int LW = vdl_pkg::LIGHT_IDX_W;

    typedef enum logic [17:0] {
        S_IDLE     = 18'b000000000000000001,
        S_AMB_MUL  = 18'b000000000000000010,
        S_AMB_WR   = 18'b000000000000000100,
        S_LSEL     = 18'b000000000000001000,
        S_DIFF     = 18'b000000000000010000,
        S_SQ_MUL   = 18'b000000000000100000,
        S_SQ_ACC   = 18'b000000000001000000,
        S_SQRT     = 18'b000000000010000000,
        S_DIV_GO   = 18'b000000000100000000,
        S_DIV_WAIT = 18'b000000001000000000,
        S_DOT_MUL  = 18'b000000010000000000,
        S_DOT_ACC  = 18'b000000100000000000,
        S_NDL      = 18'b000001000000000000,
        S_KDC_MUL  = 18'b000010000000000000,
        S_KDC      = 18'b000100000000000000,
        S_ACC_MUL  = 18'b001000000000000000,
        S_ACC_ADD  = 18'b010000000000000000,
        S_OUT      = 18'b100000000000000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [2:0][vdl_pkg::COEF_W-1:0] amb_reg;
    logic [2:0][vdl_pkg::COEF_W-1:0] kd_reg;
    logic [vdl_pkg::MASK_W-1:0]      mask_reg;

    // Light slots, one entry per slot holding all three components.
    logic [2:0][vdl_pkg::COORD_W-1:0] lvec_reg [vdl_pkg::NUM_LIGHTS];
    logic [2:0][vdl_pkg::COORD_W-1:0] lcol_reg [vdl_pkg::NUM_LIGHTS];
    logic [vdl_pkg::NUM_LIGHTS-1:0]   lkind_reg;
    logic [vdl_pkg::NUM_LIGHTS-1:0]   lvalid_reg;

    // Working registers.
    logic [2:0][vdl_pkg::COORD_W-1:0] vert_reg;
    logic [2:0][vdl_pkg::COORD_W-1:0] nrm_reg;
    logic [2:0][24:0]                 ld_reg;
    logic [2:0][55:0]                 acc_reg;
    logic [49:0]                      sum_reg;
    logic [50:0]                      dot_reg;
    logic [22:0]                      ndl_reg;
    logic [27:0]                      kdc_reg;
    logic [vdl_pkg::ROOT_W-1:0]       len_reg;
    logic signed [52:0]               prod_reg;
    logic [1:0]                       comp_reg;
    logic [LW-1:0]                    light_reg;

    logic                             out_valid_reg;
    logic [vdl_pkg::M_DATA_W-1:0]     out_data_reg;

    // Input field views.
    logic                             in_cmd;
    logic                             in_pos;
    logic [1:0]                       in_slot;
    logic [2:0][vdl_pkg::COORD_W-1:0] in_vec;
    logic [2:0][vdl_pkg::COORD_W-1:0] in_aux;
    logic                             in_xfer;

    assign in_cmd  = s_tuser[0];
    assign in_pos  = s_tuser[1];
    assign in_slot = s_tdata[1:0];
    assign in_vec  = s_tdata[73:2];
    assign in_aux  = s_tdata[145:74];
    assign in_xfer = s_tvalid && s_tready;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // Current light, reading zero until its slot is loaded.
    logic [2:0][vdl_pkg::COORD_W-1:0] cur_vec;
    logic [2:0][vdl_pkg::COORD_W-1:0] cur_col;
    logic                             cur_kind;
    logic                             last_light;

    always_comb begin
        cur_vec    = lvalid_reg[light_reg] ? lvec_reg[light_reg] : '0;
        cur_col    = lvalid_reg[light_reg] ? lcol_reg[light_reg] : '0;
        cur_kind   = lvalid_reg[light_reg] && lkind_reg[light_reg];
        last_light = (light_reg == LW'(vdl_pkg::NUM_LIGHTS - 1));
    end

    // Shared multiplier operand selection.
    logic [27:0] mul_a;
    logic [24:0] mul_b;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_AMB_MUL: begin
                mul_a = {12'd0, amb_reg[comp_reg]};
                mul_b = {9'd0, kd_reg[comp_reg]};
            end
            S_SQ_MUL: begin
                mul_a = {{3{ld_reg[comp_reg][24]}}, ld_reg[comp_reg]};
                mul_b = ld_reg[comp_reg];
            end
            S_DOT_MUL: begin
                mul_a = {{4{nrm_reg[comp_reg][23]}}, nrm_reg[comp_reg]};
                mul_b = ld_reg[comp_reg];
            end
            S_KDC_MUL: begin
                mul_a = {12'd0, kd_reg[comp_reg]};
                mul_b = {cur_col[comp_reg][23], cur_col[comp_reg]};
            end
            S_ACC_MUL: begin
                mul_a = kdc_reg;
                mul_b = {2'b00, ndl_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= $signed(mul_a) * $signed(mul_b);
    end

    // Root and divide unit signals.
    vdl_pkg::rd_ctrl_t            rd_ctrl;
    vdl_pkg::rd_stat_t            rd_stat;
    logic [vdl_pkg::RAD_W-1:0]    rd_operand;
    logic [vdl_pkg::ROOT_W-1:0]   rd_result;

    // Arithmetic around the multiplier.
    logic [49:0]                 sum_next;
    logic [50:0]                 dot_next;
    logic [24:0]                 ld_mag;
    logic [vdl_pkg::NUM_W-1:0]   div_num;
    logic [50:0]                 ndl_round;
    logic [22:0]                 ndl_next;
    logic [52:0]                 kdc_round;
    logic [24:0]                 quot;

    always_comb begin
        sum_next  = sum_reg + prod_reg[49:0];
        dot_next  = dot_reg + prod_reg[50:0];
        ld_mag    = ld_reg[comp_reg][24] ? (25'd0 - ld_reg[comp_reg]) : ld_reg[comp_reg];
        div_num   = {ld_mag, 18'd0} + {12'd0, len_reg[vdl_pkg::ROOT_W-1:1]};
        ndl_round = dot_reg + 51'd2048;
        if (dot_reg[50]) begin
            ndl_next = '0;
        end else if (ndl_round[50:12] > 39'd8388607) begin
            ndl_next = 23'd8388607;
        end else begin
            ndl_next = ndl_round[34:12];
        end
        kdc_round = prod_reg + 53'sd2048;
        quot      = rd_result[24:0];
    end

    // Root and divide unit.
    always_comb begin
        rd_ctrl.op_sqrt = (state_reg == S_SQ_ACC);
        rd_ctrl.start   = ((state_reg == S_SQ_ACC) && (comp_reg == 2'd2) &&
                           (sum_next != '0)) || (state_reg == S_DIV_GO);
        rd_operand      = rd_ctrl.op_sqrt ? {sum_next, 12'd0} : {div_num, 19'd0};
    end

    vdl_root_div u_root_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (rd_ctrl),
        .operand (rd_operand),
        .divisor (len_reg),
        .stat    (rd_stat),
        .result  (rd_result)
    );

    // Output conversion: acc times 255, rounded, saturated.
    logic [2:0][vdl_pkg::BYTE_W-1:0] byte_val;

    always_comb begin
        logic signed [63:0] acc_x;
        logic signed [63:0] t;
        logic [39:0]        r;
        for (int k = 0; k < 3; k++) begin
            acc_x = {{8{acc_reg[k][55]}}, acc_reg[k]};
            t     = (acc_x <<< 8) - acc_x;
            r     = 40'((t + 64'sd8388608) >>> 24);
            if (t <= 64'sd0) begin
                byte_val[k] = '0;
            end else if (r > 40'd255) begin
                byte_val[k] = 8'd255;
            end else begin
                byte_val[k] = r[7:0];
            end
        end
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (in_xfer && (in_cmd == vdl_pkg::CMD_SHADE)) state_next = S_AMB_MUL;
            S_AMB_MUL:  state_next = S_AMB_WR;
            S_AMB_WR:   state_next = (comp_reg == 2'd2) ? S_LSEL : S_AMB_MUL;
            S_LSEL: begin
                if (mask_reg[light_reg]) begin
                    state_next = cur_kind ? S_DIFF : S_DOT_MUL;
                end else begin
                    state_next = last_light ? S_OUT : S_LSEL;
                end
            end
            S_DIFF:     state_next = S_SQ_MUL;
            S_SQ_MUL:   state_next = S_SQ_ACC;
            S_SQ_ACC: begin
                if (comp_reg != 2'd2)   state_next = S_SQ_MUL;
                else if (sum_next == '0) state_next = S_DOT_MUL;
                else                     state_next = S_SQRT;
            end
            S_SQRT:     if (rd_stat.done) state_next = S_DIV_GO;
            S_DIV_GO:   state_next = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (rd_stat.done) state_next = (comp_reg == 2'd2) ? S_DOT_MUL : S_DIV_GO;
            end
            S_DOT_MUL:  state_next = S_DOT_ACC;
            S_DOT_ACC:  state_next = (comp_reg == 2'd2) ? S_NDL : S_DOT_MUL;
            S_NDL:      state_next = S_KDC_MUL;
            S_KDC_MUL:  state_next = S_KDC;
            S_KDC:      state_next = S_ACC_MUL;
            S_ACC_MUL:  state_next = S_ACC_ADD;
            S_ACC_ADD: begin
                if (comp_reg != 2'd2) state_next = S_KDC_MUL;
                else                  state_next = last_light ? S_OUT : S_LSEL;
            end
            S_OUT:      if (!out_valid_reg || m_tready) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            lvalid_reg    <= '0;
            lkind_reg     <= '0;
            amb_reg       <= {3{vdl_pkg::AMBIENT_RESET}};
            kd_reg        <= {3{vdl_pkg::DIFFUSE_RESET}};
            mask_reg      <= '0;
        end else begin
            state_reg <= state_next;

            // Result register.
            if ((state_reg == S_OUT) && (!out_valid_reg || m_tready)) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            // Slot load.
            if (in_xfer && (in_cmd == vdl_pkg::CMD_LOAD)) begin
                lvalid_reg[in_slot] <= 1'b1;
                lkind_reg[in_slot]  <= in_pos;
            end

            // Configuration transfer.
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    vdl_pkg::REG_AMBIENT_RED:   amb_reg[0] <= cfg_data;
                    vdl_pkg::REG_AMBIENT_GREEN: amb_reg[1] <= cfg_data;
                    vdl_pkg::REG_AMBIENT_BLUE:  amb_reg[2] <= cfg_data;
                    vdl_pkg::REG_DIFFUSE_RED:   kd_reg[0]  <= cfg_data;
                    vdl_pkg::REG_DIFFUSE_GREEN: kd_reg[1]  <= cfg_data;
                    vdl_pkg::REG_DIFFUSE_BLUE:  kd_reg[2]  <= cfg_data;
                    vdl_pkg::REG_LIGHT_ENABLE:  mask_reg   <= cfg_data[vdl_pkg::MASK_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge aclk) begin
        if (in_xfer && (in_cmd == vdl_pkg::CMD_LOAD)) begin
            lvec_reg[in_slot] <= in_vec;
            lcol_reg[in_slot] <= in_aux;
        end

        if ((state_reg == S_OUT) && (!out_valid_reg || m_tready)) begin
            out_data_reg <= {byte_val[2], byte_val[1], byte_val[0]};
        end

        case (state_reg)
            S_IDLE: begin
                vert_reg  <= in_vec;
                nrm_reg   <= in_aux;
                comp_reg  <= '0;
                light_reg <= '0;
            end
            S_AMB_WR: begin
                acc_reg[comp_reg] <= {{3{prod_reg[52]}}, prod_reg};
                comp_reg          <= (comp_reg == 2'd2) ? 2'd0 : comp_reg + 2'd1;
            end
            S_LSEL: begin
                comp_reg <= '0;
                dot_reg  <= '0;
                for (int k = 0; k < 3; k++) begin
                    ld_reg[k] <= {cur_vec[k][23], cur_vec[k]};
                end
                if (!mask_reg[light_reg] && !last_light) light_reg <= light_reg + 1'b1;
            end
            S_DIFF: begin
                sum_reg <= '0;
                for (int k = 0; k < 3; k++) begin
                    ld_reg[k] <= {cur_vec[k][23], cur_vec[k]} - {vert_reg[k][23], vert_reg[k]};
                end
            end
            S_SQ_ACC: begin
                sum_reg  <= sum_next;
                comp_reg <= (comp_reg == 2'd2) ? 2'd0 : comp_reg + 2'd1;
            end
            S_SQRT: begin
                if (rd_stat.done) len_reg <= rd_result;
            end
            S_DIV_WAIT: begin
                if (rd_stat.done) begin
                    ld_reg[comp_reg] <= ld_reg[comp_reg][24] ? (25'd0 - quot) : quot;
                    comp_reg         <= (comp_reg == 2'd2) ? 2'd0 : comp_reg + 2'd1;
                end
            end
            S_DOT_ACC: begin
                dot_reg  <= dot_next;
                comp_reg <= (comp_reg == 2'd2) ? 2'd0 : comp_reg + 2'd1;
            end
            S_NDL: begin
                ndl_reg  <= ndl_next;
                comp_reg <= '0;
            end
            S_KDC: begin
                kdc_reg <= kdc_round[39:12];
            end
            S_ACC_ADD: begin
                acc_reg[comp_reg] <= acc_reg[comp_reg] + {{3{prod_reg[52]}}, prod_reg};
                comp_reg          <= (comp_reg == 2'd2) ? 2'd0 : comp_reg + 2'd1;
                if ((comp_reg == 2'd2) && !last_light) light_reg <= light_reg + 1'b1;
            end
            default: ;
        endcase
    end

endmodule

### rtl/core/vdl_checker.sv
// Port-level checks of the vertex lighting block, bound to its top level.
// Depends on vertex_diffuse_lighting_unit_assert.svh.
`timescale 1ns / 1ps

`include "vertex_diffuse_lighting_unit_assert.svh"

module vdl_port_checks (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // A shade transfer occupies the block on the following cycle.
    `VDL_ASSERT_NEXT(a_shade_busy, s_tvalid && s_tready && s_tuser[0], !s_tready)

    // A load transfer leaves the block ready for the next item.
    `VDL_ASSERT_NEXT(a_load_ready, s_tvalid && s_tready && !s_tuser[0], s_tready)

    // A new result only appears after the block was busy computing it.
    `VDL_ASSERT_NOW(a_result_after_work, $rose(m_tvalid), !$past(s_tready))

    // A stalled result holds.
    `VDL_ASSERT_NEXT(a_result_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind vertex_diffuse_lighting_unit vdl_port_checks u_vdl_port_checks (.*);
